// File: hw/rtl/jbce_pkg.sv
// ----------------------------------------------------------------------------
// jbce_pkg : shared types and constants of the JTAG byte command engine
// Command codes, parse phases and the state and result words that pass
// between the parser and the top level.
// ----------------------------------------------------------------------------
package jbce_pkg;

   localparam int unsigned ByteW = 8;

   // host command codes
   localparam logic [ByteW-1:0] CMD_SETUP    = 8'd0;
   localparam logic [ByteW-1:0] CMD_SHUTDOWN = 8'd1;
   localparam logic [ByteW-1:0] CMD_SINGLE   = 8'd2;
   localparam logic [ByteW-1:0] CMD_PULSE    = 8'd3;
   localparam logic [ByteW-1:0] CMD_REPEAT   = 8'd4;
   localparam logic [ByteW-1:0] CMD_MULTI    = 8'd5;

   // argument byte that abandons the command being parsed
   localparam logic [ByteW-1:0] ABORT_BYTE = 8'hff;

   // multi pulse item bits
   localparam int unsigned ITEM_TMS_BIT     = 0;
   localparam int unsigned ITEM_TDI_EN_BIT  = 1;
   localparam int unsigned ITEM_TDI_BIT     = 2;
   localparam int unsigned ITEM_CMP_EN_BIT  = 3;
   localparam int unsigned ITEM_CMP_VAL_BIT = 4;

   typedef enum logic [2:0] {
      PH_CMD        = 3'd0,
      PH_SINGLE     = 3'd1,
      PH_REP_TMS    = 3'd2,
      PH_REP_COUNT  = 3'd3,
      PH_MULTI_CNT  = 3'd4,
      PH_MULTI_ITEM = 3'd5
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [ByteW-1:0] items_left;
      logic             saved_tms;
      logic             match_ok;
      logic             tms;
      logic             tdi;
      logic             tck;
      logic             drive_en;
      logic             eng_ready;
      logic             led;
   } state_type;

   typedef struct packed {
      logic             tms_level;
      logic             tdi_level;
      logic             tck_level;
      logic             pins_driven;
      logic             led_on;
      logic [ByteW-1:0] tck_pulses;
      logic             reply_valid;
      logic             reply_byte;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:      PH_CMD,
      items_left: '0,
      saved_tms:  1'b0,
      match_ok:   1'b1,
      tms:        1'b0,
      tdi:        1'b0,
      tck:        1'b0,
      drive_en:   1'b0,
      eng_ready:  1'b0,
      led:        1'b0
   };

endpackage

// File: hw/rtl/jbce_if.sv
// ----------------------------------------------------------------------------
// jbce_req_if / jbce_rsp_if : valid-ready channels of the engine
// A word moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface jbce_req_if;
   import jbce_pkg::*;
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] rx_byte;
   logic             tdo_level;

   modport source (output valid, output rx_byte, output tdo_level, input ready);
   modport sink   (input valid, input rx_byte, input tdo_level, output ready);
endinterface

interface jbce_rsp_if;
   import jbce_pkg::*;
   logic             valid;
   logic             ready;
   logic             tms_level;
   logic             tdi_level;
   logic             tck_level;
   logic             pins_driven;
   logic             led_on;
   logic [ByteW-1:0] tck_pulses;
   logic             reply_valid;
   logic             reply_byte;

   modport source (output valid, output tms_level, output tdi_level, output tck_level,
                   output pins_driven, output led_on, output tck_pulses,
                   output reply_valid, output reply_byte, input ready);
   modport sink   (input valid, input tms_level, input tdi_level, input tck_level,
                   input pins_driven, input led_on, input tck_pulses,
                   input reply_valid, input reply_byte, output ready);
endinterface

// File: hw/rtl/jbce_parser.sv
// ----------------------------------------------------------------------------
// jbce_parser : one-byte step of the command parser
// Next parse state and the result word for one host byte.
// ----------------------------------------------------------------------------
module jbce_parser
   import jbce_pkg::*;
(
   input  state_type        cur_state,
   input  logic [ByteW-1:0] rx_byte,
   input  logic             tdo_level,
   output state_type        nxt_state,
   output result_type       result
);

   logic [ByteW-1:0] pulses;
   logic             rvalid;
   logic             rbyte;
   logic             is_abort;
   logic [ByteW-1:0] items_dec;
   logic             match_now;

   assign is_abort  = (rx_byte == ABORT_BYTE);
   assign items_dec = cur_state.items_left - ByteW'(1);

   always_comb begin
      nxt_state = cur_state;
      pulses    = '0;
      rvalid    = 1'b0;
      rbyte     = 1'b0;
      match_now = cur_state.match_ok;

      unique case (cur_state.phase)
         PH_CMD: begin
            if (cur_state.eng_ready) begin
               nxt_state.led = ~cur_state.led;
            end
            case (rx_byte)
               CMD_SETUP: begin
                  nxt_state.tms       = 1'b0;
                  nxt_state.tdi       = 1'b0;
                  nxt_state.tck       = 1'b0;
                  nxt_state.drive_en  = 1'b1;
                  nxt_state.eng_ready = 1'b1;
                  nxt_state.led       = 1'b1;
               end
               CMD_SHUTDOWN: begin
                  nxt_state.tms       = 1'b0;
                  nxt_state.tdi       = 1'b0;
                  nxt_state.tck       = 1'b0;
                  nxt_state.drive_en  = 1'b0;
                  nxt_state.eng_ready = 1'b0;
                  nxt_state.led       = 1'b0;
               end
               CMD_SINGLE: nxt_state.phase = PH_SINGLE;
               CMD_PULSE: begin
                  nxt_state.tck = 1'b1;
                  pulses        = ByteW'(1);
               end
               CMD_REPEAT: nxt_state.phase = PH_REP_TMS;
               CMD_MULTI:  nxt_state.phase = PH_MULTI_CNT;
               default: ;  // unknown command: only the LED moves, and only when set up
            endcase
         end

         PH_SINGLE: begin
            nxt_state.phase = PH_CMD;
            if (!is_abort) begin
               nxt_state.tms = rx_byte[0];
               nxt_state.tdi = rx_byte[1];
               nxt_state.tck = 1'b1;
               pulses        = ByteW'(1);
               rvalid        = 1'b1;
               rbyte         = tdo_level;
            end
         end

         PH_REP_TMS: begin
            if (is_abort) begin
               nxt_state.phase = PH_CMD;
            end else begin
               nxt_state.saved_tms = (rx_byte != '0);
               nxt_state.phase     = PH_REP_COUNT;
            end
         end

         PH_REP_COUNT: begin
            nxt_state.phase = PH_CMD;
            if (!is_abort) begin
               nxt_state.tms = cur_state.saved_tms;
               pulses        = rx_byte;
               if (rx_byte != '0) begin
                  nxt_state.tck = 1'b1;
               end
            end
         end

         PH_MULTI_CNT: begin
            if (is_abort) begin
               nxt_state.phase = PH_CMD;
            end else begin
               nxt_state.match_ok = 1'b1;
               if (rx_byte == '0) begin
                  nxt_state.phase = PH_CMD;
                  rvalid          = 1'b1;
                  rbyte           = 1'b1;
               end else begin
                  nxt_state.items_left = rx_byte;
                  nxt_state.phase      = PH_MULTI_ITEM;
               end
            end
         end

         PH_MULTI_ITEM: begin
            if (is_abort) begin
               nxt_state.phase      = PH_CMD;
               nxt_state.items_left = '0;
            end else begin
               nxt_state.tms = rx_byte[ITEM_TMS_BIT];
               if (rx_byte[ITEM_TDI_EN_BIT]) begin
                  nxt_state.tdi = rx_byte[ITEM_TDI_BIT];
               end
               nxt_state.tck = 1'b1;
               pulses        = ByteW'(1);
               if (rx_byte[ITEM_CMP_EN_BIT] && (rx_byte[ITEM_CMP_VAL_BIT] != tdo_level)) begin
                  match_now = 1'b0;
               end
               nxt_state.match_ok   = match_now;
               nxt_state.items_left = items_dec;
               if (items_dec == '0) begin
                  nxt_state.phase = PH_CMD;
                  rvalid          = 1'b1;
                  rbyte           = match_now;
               end
            end
         end

         default: nxt_state.phase = PH_CMD;
      endcase
   end

   always_comb begin
      result.tms_level   = nxt_state.tms;
      result.tdi_level   = nxt_state.tdi;
      result.tck_level   = nxt_state.tck;
      result.pins_driven = nxt_state.drive_en;
      result.led_on      = nxt_state.led;
      result.tck_pulses  = pulses;
      result.reply_valid = rvalid;
      result.reply_byte  = rbyte;
   end

endmodule

// File: hw/rtl/jtag_byte_command_engine_core.sv
// ----------------------------------------------------------------------------
// jtag_byte_command_engine_core : host byte parser for a JTAG pin driver
// Parses setup, shutdown, single, plain, repeated and multi pulse commands
// and gives the pin levels, pulse count and reply for every host byte.
// ----------------------------------------------------------------------------
// Use:
//   req_ch carries one host word: rx_byte and the TDO level sampled after
//   that byte's TCK edge. rsp_ch returns exactly one word per request word:
//   pin levels after the byte, drive enable, LED, TCK pulse count and an
//   optional reply bit (TDO or multi pulse ok flag).
// Latency: the response word is valid the cycle after its request word is
//   taken; the parse step is one pass of logic into the response register.
// Throughput: one word per cycle. req_ch.ready stays high while the
//   response register is empty or being emptied in the same cycle.
// Stall: when rsp_ch.ready is low with a word held, req_ch.ready drops and
//   the held word and parse state stay put until the word is taken.
// Reset (synchronous): parser waits for a command, pins low and
//   undriven, engine not set up, LED off, response register empty.
// An argument byte of 0xff abandons the command with no reply.
// ----------------------------------------------------------------------------
module jtag_byte_command_engine_core
   import jbce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   jbce_req_if.sink   req_ch,
   jbce_rsp_if.source rsp_ch
);

   state_type  state_ff;
   state_type  state_in;
   result_type rsp_word_ff;
   result_type rsp_word_in;
   logic       rsp_valid_ff;
   logic       req_take;

   // free to take a word when nothing is held or the held word leaves now
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   jbce_parser u_parser (
      .cur_state (state_ff),
      .rx_byte   (req_ch.rx_byte),
      .tdo_level (req_ch.tdo_level),
      .nxt_state (state_in),
      .result    (rsp_word_in)
   );

   // parse state, response word and its valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_word_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff     <= state_in;
            rsp_word_ff  <= rsp_word_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.tms_level   = rsp_word_ff.tms_level;
   assign rsp_ch.tdi_level   = rsp_word_ff.tdi_level;
   assign rsp_ch.tck_level   = rsp_word_ff.tck_level;
   assign rsp_ch.pins_driven = rsp_word_ff.pins_driven;
   assign rsp_ch.led_on      = rsp_word_ff.led_on;
   assign rsp_ch.tck_pulses  = rsp_word_ff.tck_pulses;
   assign rsp_ch.reply_valid = rsp_word_ff.reply_valid;
   assign rsp_ch.reply_byte  = rsp_word_ff.reply_byte;

   // a taken request always leaves a response word behind
   a_take_gives_word : assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("request taken without response word");

   // no reply bit without a reply
   a_reply_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.reply_valid || !rsp_word_ff.reply_byte))
      else $error("reply bit set without reply");

   // any pulse leaves TCK high
   a_pulse_tck : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff.tck_pulses != '0)) |-> rsp_word_ff.tck_level)
      else $error("TCK low after pulses");

   // pins are driven exactly while the engine is set up
   a_drive_ready : assert property (@(posedge clock) disable iff (reset)
      state_ff.drive_en == state_ff.eng_ready)
      else $error("drive enable and engine state disagree");

   // item countdown zero in the command and single phases (non-zero only inside a multi pulse)
   a_items_phase : assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_CMD || state_ff.phase == PH_SINGLE)
         |-> (state_ff.items_left == '0))
      else $error("items left outside multi pulse");

endmodule
